// ===== hw/rtl/bfa_pkg.sv =====
// Shared types and constants for the bitmap frame allocator.
// Used by bfa_ctrl, bfa_dp and bitmap_frame_allocator; no dependencies.
package bfa_pkg;

  localparam int FRAME_W         = 14;
  localparam int FRAME_LIMIT     = 16384;
  localparam int WORD_BITS       = 32;
  localparam int BIT_W           = 5;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 14;
  localparam int MAP_WORDS_DEF   = 256;
  localparam int START_FRAME_DEF = 512;

  localparam logic [FRAME_W-1:0] POOL_FIRST_RST = FRAME_W'(512);
  localparam logic [FRAME_W-1:0] POOL_COUNT_RST = FRAME_W'(8192);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_FIRST = 2'd0,
    REG_POOL_COUNT = 2'd1,
    REG_SPARE2     = 2'd2,
    REG_SPARE3     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_MARK    = 2'd2,
    ACT_NONE    = 2'd3
  } act_t;

  typedef struct packed {
    act_t               action;
    logic [FRAME_W-1:0] frame;
    logic [FRAME_W-1:0] count;
  } in_word_t;

  typedef struct packed {
    logic [FRAME_W-1:0] alloc_frame;
    logic               ok;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic setup;
    logic rd_issue;
    logic eval;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    act_t op;
    logic empty;
    logic rd_more;
    logic ev_vld;
    logic ev_last;
    logic found;
  } sts_t;

endpackage

// ===== hw/rtl/bfa_ctrl.sv =====
// Controller FSM for the bitmap frame allocator: clear pass, item intake,
// word scan sequencing and result hand-off. Depends on bfa_pkg.
module bfa_ctrl
  import bfa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        if (sts.op == ACT_NONE || sts.empty) state_nxt = ST_RESP;
        else                                 state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.rd_issue = sts.rd_more;
        if (sts.ev_vld) begin
          cmd.eval = 1'b1;
          if ((sts.op == ACT_ALLOC && sts.found) || sts.ev_last) state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);
  assign out_valid     = out_valid_r;

endmodule

// ===== hw/rtl/bfa_dp.sv =====
// Datapath for the bitmap frame allocator: pool registers, range setup,
// used-bit memory with read-modify-write scan, result and output registers.
// Depends on bfa_pkg.
module bfa_dp
  import bfa_pkg::*;
#(
  parameter int MAP_WORDS   = MAP_WORDS_DEF,
  parameter int START_FRAME = START_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_data,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output out_word_t             out_data
);

  localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SPAN  = MAP_WORDS * WORD_BITS;
  localparam int LW    = $clog2(START_FRAME + SPAN + 2 * FRAME_LIMIT + 1);
  localparam int MAP_END = START_FRAME + SPAN;

  logic [FRAME_W-1:0]   pool_first_r, pool_count_r;
  in_word_t             item_r;
  logic [AW-1:0]        clr_addr_r;
  logic [AW-1:0]        lo_word_r, last_word_r, rd_word_r, ev_word_r;
  logic [BIT_W-1:0]     lo_b5_r, last_b5_r;
  logic                 empty_r, rd_more_r, ev_vld_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic [FRAME_W-1:0]   res_frame_r;
  logic                 res_ok_r;
  out_word_t            out_r;
  logic [WORD_BITS-1:0] mem [MAP_WORDS];

  // range setup
  logic [FRAME_W-1:0] base, len;
  logic [LW-1:0]      end0, end1, end2, lo_abs, lo_rel, last_rel;
  logic               empty_c;

  always_comb begin
    unique case (item_r.action)
      ACT_ALLOC: begin
        base = pool_first_r;
        len  = pool_count_r;
      end
      ACT_RELEASE: begin
        base = item_r.frame;
        len  = FRAME_W'(1);
      end
      ACT_MARK: begin
        base = item_r.frame;
        len  = item_r.count;
      end
      default: begin
        base = '0;
        len  = '0;
      end
    endcase
    end0     = LW'(base) + LW'(len);
    end1     = (end0 > LW'(FRAME_LIMIT)) ? LW'(FRAME_LIMIT) : end0;
    end2     = (end1 > LW'(MAP_END)) ? LW'(MAP_END) : end1;
    lo_abs   = (LW'(base) < LW'(START_FRAME)) ? LW'(START_FRAME) : LW'(base);
    empty_c  = (end2 <= lo_abs);
    lo_rel   = lo_abs - LW'(START_FRAME);
    last_rel = end2 - LW'(1) - LW'(START_FRAME);
  end

  // word evaluation
  logic [WORD_BITS-1:0] mask_lo, mask_hi, mask, free, iso, wdata;
  logic [BIT_W-1:0]     idx;
  logic                 found, hit, we_ev;
  logic [LW-1:0]        frame_abs;

  always_comb begin
    mask_lo = (ev_word_r == lo_word_r) ? ('1 << lo_b5_r) : '1;
    mask_hi = (ev_word_r == last_word_r) ? ('1 >> (BIT_W'(WORD_BITS - 1) - last_b5_r)) : '1;
    mask    = mask_lo & mask_hi;
    free    = ~rdata_r & mask;
    iso     = free & (~free + WORD_BITS'(1));
    found   = |free;
    hit     = |(rdata_r & mask);
    for (int k = 0; k < BIT_W; k++) begin
      idx[k] = 1'b0;
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> k) & 1) == 1) idx[k] = idx[k] | iso[i];
      end
    end
    frame_abs = LW'(START_FRAME) + LW'({ev_word_r, idx});
    unique case (item_r.action)
      ACT_ALLOC: begin
        wdata = rdata_r | iso;
        we_ev = found;
      end
      ACT_RELEASE: begin
        wdata = rdata_r & ~mask;
        we_ev = 1'b1;
      end
      ACT_MARK: begin
        wdata = rdata_r | mask;
        we_ev = 1'b1;
      end
      default: begin
        wdata = rdata_r;
        we_ev = 1'b0;
      end
    endcase
  end

  // used-bit memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.clr_step) mem[clr_addr_r] <= '0;
    else if (cmd.eval && we_ev) mem[ev_word_r] <= wdata;
    if (cmd.rd_issue) rdata_r <= mem[rd_word_r];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_first_r <= POOL_FIRST_RST;
      pool_count_r <= POOL_COUNT_RST;
      clr_addr_r   <= '0;
      rd_more_r    <= 1'b0;
      ev_vld_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_reg_t'(cfg_idx) == REG_POOL_FIRST) pool_first_r <= cfg_wdata;
      if (cfg_we && cfg_reg_t'(cfg_idx) == REG_POOL_COUNT) pool_count_r <= cfg_wdata;
      if (cmd.clr_step) clr_addr_r <= clr_addr_r + AW'(1);
      ev_vld_r <= cmd.rd_issue;
      if (cmd.setup) rd_more_r <= ~empty_c;
      else if (cmd.rd_issue && rd_word_r == last_word_r) rd_more_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    if (cmd.setup) begin
      lo_word_r   <= lo_rel[AW+BIT_W-1:BIT_W];
      last_word_r <= last_rel[AW+BIT_W-1:BIT_W];
      lo_b5_r     <= lo_rel[BIT_W-1:0];
      last_b5_r   <= last_rel[BIT_W-1:0];
      rd_word_r   <= lo_rel[AW+BIT_W-1:BIT_W];
      empty_r     <= empty_c;
      res_frame_r <= '0;
      res_ok_r    <= (item_r.action == ACT_MARK);
    end else begin
      if (cmd.rd_issue) begin
        rd_word_r <= rd_word_r + AW'(1);
        ev_word_r <= rd_word_r;
      end
      if (cmd.eval) begin
        if (item_r.action == ACT_ALLOC && found) begin
          res_frame_r <= frame_abs[FRAME_W-1:0];
          res_ok_r    <= 1'b1;
        end else if (item_r.action == ACT_RELEASE) begin
          res_ok_r <= hit;
        end
      end
    end
    if (cmd.load_out) begin
      out_r.alloc_frame <= res_frame_r;
      out_r.ok          <= res_ok_r;
    end
  end

  always_comb begin
    sts.clr_last = (clr_addr_r == AW'(MAP_WORDS - 1));
    sts.op       = item_r.action;
    sts.empty    = empty_c;
    sts.rd_more  = rd_more_r & ~empty_r;
    sts.ev_vld   = ev_vld_r;
    sts.ev_last  = (ev_word_r == last_word_r);
    sts.found    = found;
  end

  assign out_data = out_r;

endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// First-fit frame allocator over a used-bit map of MAP_WORDS 32-bit words,
// covering frames START_FRAME up to START_FRAME + 32*MAP_WORDS - 1. After reset
// the map is zeroed by a clearing pass over every map word, during which no word
// is taken in (configuration writes still are). One word is handled at a time:
// allocate, mark and release visit the map words of their range, one per cycle
// through the single memory read port, allocation stopping at the first word
// holding a free frame; an empty range or action 3 visits none. The next word is
// taken in once the result has moved to the output register.
// Depends on bfa_pkg, bfa_ctrl and bfa_dp.
module bitmap_frame_allocator
  import bfa_pkg::*;
#(
  parameter int MAP_WORDS   = MAP_WORDS_DEF,
  parameter int START_FRAME = START_FRAME_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  cmd_t cmd;
  sts_t sts;

  bfa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfa_dp #(
    .MAP_WORDS   (MAP_WORDS),
    .START_FRAME (START_FRAME)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== sim/bitmap_frame_allocator_tb.sv =====
// Self-checking testbench for bitmap_frame_allocator: directed and random
// allocate/release/mark words checked against an in-bench bitmap predictor.
// Depends on bfa_pkg and the bitmap_frame_allocator RTL.
module bitmap_frame_allocator_tb;
  import bfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAP_WORDS   = MAP_WORDS_DEF;
  localparam int START_FRAME = START_FRAME_DEF;
  localparam int MAP_END     = START_FRAME + MAP_WORDS * WORD_BITS;
  localparam int LIMIT       = 2_000_000;
  localparam int LONG_HOLD   = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;

  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  logic [FRAME_W-1:0]   pool_first = POOL_FIRST_RST;
  logic [FRAME_W-1:0]   pool_count = POOL_COUNT_RST;

  out_word_t   awaited_answers [$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  bit          quiet = 1'b0;
  logic        hold_pending = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  bitmap_frame_allocator #(
    .MAP_WORDS  (MAP_WORDS),
    .START_FRAME(START_FRAME)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    foreach (used_map[i]) used_map[i] = '0;
  end

  function automatic bit in_map(int f);
    return (f >= START_FRAME) && (f < MAP_END);
  endfunction

  // bitmap update and answer for one accepted word
  function automatic out_word_t apply_request(in_word_t w);
    out_word_t r;
    int f, stop, b;
    r = '0;
    case (w.action)
      ACT_ALLOC: begin
        stop = int'(pool_first) + int'(pool_count);
        if (stop > FRAME_LIMIT) stop = FRAME_LIMIT;
        for (f = int'(pool_first); f < stop && !r.ok; f++) begin
          if (in_map(f)) begin
            b = f - START_FRAME;
            if (!used_map[b / WORD_BITS][b % WORD_BITS]) begin
              used_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
              r.alloc_frame = FRAME_W'(f);
              r.ok = 1'b1;
            end
          end
        end
      end
      ACT_RELEASE: begin
        f = int'(w.frame);
        if (in_map(f)) begin
          b = f - START_FRAME;
          if (used_map[b / WORD_BITS][b % WORD_BITS]) begin
            used_map[b / WORD_BITS][b % WORD_BITS] = 1'b0;
            r.ok = 1'b1;
          end
        end
      end
      ACT_MARK: begin
        stop = int'(w.frame) + int'(w.count);
        if (stop > FRAME_LIMIT) stop = FRAME_LIMIT;
        for (f = int'(w.frame); f < stop; f++) begin
          if (in_map(f)) begin
            b = f - START_FRAME;
            used_map[b / WORD_BITS][b % WORD_BITS] = 1'b1;
          end
        end
        r.ok = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(act_t op, logic [FRAME_W-1:0] fr, logic [FRAME_W-1:0] ct);
    in_word_t    w;
    int unsigned gap;
    w = {op, fr, ct};
    gap = quiet ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_answers.push_back(apply_request(w));
  endtask

  // drop valid, wait for every answer, leave the block idle
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= r;
    cfg_wdata <= v;
    @(posedge clk);
    case (r)
      REG_POOL_FIRST: pool_first = v;
      REG_POOL_COUNT: pool_count = v;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_basic_ops();
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, 14'h3FFF, 14'h3FFF);
    send_word(ACT_RELEASE, 14'd512, '0);
    send_word(ACT_RELEASE, 14'd512, 14'h3FFF);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_RELEASE, 14'd0, '0);
    send_word(ACT_RELEASE, 14'(MAP_END), '0);
    send_word(ACT_RELEASE, 14'h3FFF, '0);
    send_word(ACT_MARK, 14'd600, 14'd0);
    send_word(ACT_MARK, 14'd514, 14'd30);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_MARK, 14'(MAP_END - 14), 14'h3FFF);
    send_word(ACT_NONE, 14'h3FFF, 14'h3FFF);
    send_word(ACT_NONE, '0, '0);
    send_word(ACT_RELEASE, 14'(MAP_END - 1), '0);
    send_word(ACT_MARK, 14'd0, 14'd520);
    send_word(ACT_MARK, 14'h3FFF, 14'd1);
  endtask

  task automatic test_pool_limits();
    settle();
    write_reg(REG_POOL_COUNT, '0);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, 14'h3FFF);
    write_reg(REG_POOL_COUNT, 14'h3FFF);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, 14'(MAP_END - 4));
    write_reg(REG_POOL_COUNT, 14'd100);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, '0);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, 14'd500);
    write_reg(REG_POOL_COUNT, 14'd20);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_SPARE2, 14'h3FFF);
    write_reg(REG_SPARE3, 14'h3FFF);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_RELEASE, 14'd515, '0);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, POOL_FIRST_RST);
    write_reg(REG_POOL_COUNT, POOL_COUNT_RST);
  endtask

  task automatic test_output_stall();
    int n;
    settle();
    quiet = 1'b1;
    hold_pending <= 1'b1;
    for (n = 0; n < 24; n++) begin
      case (n % 3)
        0: send_word(ACT_ALLOC, 14'($urandom), 14'($urandom));
        1: send_word(ACT_RELEASE, 14'(pool_first + $urandom_range(0, 40)), '0);
        default: send_word(ACT_MARK, 14'(pool_first + $urandom_range(0, 60)),
                           14'($urandom_range(0, 8)));
      endcase
    end
    settle();
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase, n, sel, span;
    logic [FRAME_W-1:0] fr, ct;
    for (phase = 0; phase < 28; phase++) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0: begin
          write_reg(REG_POOL_COUNT, 14'($urandom));
          write_reg(REG_POOL_FIRST, 14'($urandom));
        end
        1: begin
          write_reg(REG_POOL_FIRST, $urandom_range(0, 1) ? 14'h3FFF : 14'h0);
          write_reg(REG_POOL_COUNT, $urandom_range(0, 1) ? 14'h3FFF : 14'h0);
        end
        default: begin
          write_reg(REG_POOL_FIRST, 14'($urandom_range(START_FRAME - 40, MAP_END - 20)));
          write_reg(REG_POOL_COUNT, 14'($urandom_range(1, 64)));
        end
      endcase
      span = (pool_count > 200) ? 200 : int'(pool_count) + 4;
      for (n = 0; n < 50; n++) begin
        sel = $urandom_range(0, 99);
        fr = 14'($urandom);
        ct = 14'($urandom);
        if (sel < 45)
          send_word(ACT_ALLOC, fr, ct);
        else if (sel < 72)
          send_word(ACT_RELEASE, 14'(pool_first + $urandom_range(0, span)), ct);
        else if (sel < 77)
          send_word(ACT_RELEASE, fr, ct);
        else if (sel < 93)
          send_word(ACT_MARK, 14'(pool_first + $urandom_range(0, span) - 2),
                    14'($urandom_range(0, 40)));
        else if (sel < 95)
          send_word(ACT_MARK, fr, ct);
        else
          send_word(ACT_NONE, fr, ct);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_full_map();
    settle();
    write_reg(REG_POOL_FIRST, POOL_FIRST_RST);
    write_reg(REG_POOL_COUNT, POOL_COUNT_RST);
    send_word(ACT_MARK, 14'd0, 14'h3FFF);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_RELEASE, 14'd9000, '0);
    send_word(ACT_RELEASE, 14'd8000, '0);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);
    settle();
    write_reg(REG_POOL_FIRST, 14'(MAP_END - 1));
    write_reg(REG_POOL_COUNT, 14'd1);
    send_word(ACT_RELEASE, 14'(MAP_END - 1), '0);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_ops();
    test_pool_limits();
    test_output_stall();
    test_random_traffic();
    test_full_map();
    settle();
    repeat (300) @(posedge clk);
    if (mismatches == 0)
      $display("bitmap_frame_allocator_tb OK");
    else
      $display("bitmap_frame_allocator_tb NOT OK");
    $finish;
  end

  // receiver: per-word stall, plus one long hold on request
  always @(posedge clk) begin : rx_ready
    int unsigned pause;
    if (hold_pending) begin
      hold_pending <= 1'b0;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      pause = quiet ? 0 : $urandom_range(0, 13);
      if (pause == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= pause - 1;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : answer_check
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected word: alloc_frame %0d ok %0d",
               out_data.alloc_frame, out_data.ok);
        mismatches++;
      end else begin
        want = awaited_answers.pop_front();
        if (out_data.alloc_frame !== want.alloc_frame) begin
          $error("alloc_frame: expected %0d, got %0d",
                 want.alloc_frame, out_data.alloc_frame);
          mismatches++;
        end
        if (out_data.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("bitmap_frame_allocator_tb NOT OK");
      $finish;
    end
  end

endmodule
